// ===== hw/rtl/fpexp_pkg.sv =====
package fpexp_pkg;

  // Unpacked working float: value = m * 2^(e - 23), m has its leading one at
  // bit 23 unless the value is zero.
  typedef struct packed {
    logic              sgn;
    logic signed [9:0] e;
    logic [23:0]       m;
  } ufp_t;

  // Override carried beside the arithmetic for special and saturated inputs.
  typedef struct packed {
    logic              ovr;
    logic [31:0]       bits;
    logic              flag;
    logic signed [9:0] k;
  } fpexp_sb_t;

  // Input register to result register, in clock cycles.
  localparam int LATENCY = 20;

  localparam logic [31:0] POS_INF_BITS = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT    = 32'h0040_0000;

  // Significands of log2(e) and ln(2) as single-precision values.
  localparam logic [23:0] LOG2E_M = 24'hB8AA3B;
  localparam logic [23:0] LN2_M   = 24'hB17218;

  // Polynomial coefficients, rounded to single precision.
  localparam ufp_t C4_F  = '{sgn: 1'b0, e: -10'sd5, m: 24'hAD7D7D};
  localparam ufp_t C3_F  = '{sgn: 1'b0, e: -10'sd3, m: 24'hAAF080};
  localparam ufp_t C2_F  = '{sgn: 1'b0, e: -10'sd2, m: 24'hFFF205};
  localparam ufp_t C1_F  = '{sgn: 1'b0, e: 10'sd0,  m: 24'h80016A};
  localparam ufp_t ONE_F = '{sgn: 1'b0, e: 10'sd0,  m: 24'h800000};

endpackage

// ===== hw/rtl/fpexp_fma.sv =====
// Three-stage fused multiply-add y = a*b + c with one round to nearest even.
// The addend is a positive constant and the sum stays in [2^-7, 2).
module fpexp_fma import fpexp_pkg::*; (
  input  logic clk,
  input  ufp_t a,
  input  ufp_t b,
  input  ufp_t c,
  output ufp_t y
);

  logic [47:0]       pr;
  logic signed [9:0] ep;
  logic              ps;
  ufp_t              ca;
  logic [56:0]       sm;

  logic signed [9:0] sh;
  logic signed [9:0] n;
  logic [5:0]        nc;
  logic [111:0]      w;
  logic [56:0]       pal;
  logic              st;
  logic [56:0]       pmag;
  logic [56:0]       cfix;
  logic [56:0]       sum_c;

  logic [2:0]        lz;
  logic [56:0]       nrm;
  logic [23:0]       mant;
  logic              rb;
  logic              stc;
  logic [24:0]       mr;
  ufp_t              y_next;

  // Exact product.
  always_ff @(posedge clk) begin
    pr <= a.m * b.m;
    ep <= a.e + b.e;
    ps <= a.sgn ^ b.sgn;
    ca <= c;
  end

  // Place the product on a grid with its lowest bit at 2^-56; bits below it
  // are jammed into the lowest bit, which is far below the rounding point.
  always_comb begin
    sh   = ep + 10'sd10;
    n    = -sh;
    nc   = (n > 10'sd63) ? 6'd63 : n[5:0];
    w    = {pr, 64'b0} >> nc;
    if (!sh[9]) begin
      pal = 57'(pr) << sh[3:0];
      st  = 1'b0;
    end else begin
      pal = 57'(w[111:64]);
      st  = |w[63:0];
    end
    pmag  = pal | 57'(st);
    cfix  = 57'(ca.m) << 6'(ca.e + 10'sd33);
    sum_c = ps ? (cfix - pmag) : (cfix + pmag);
  end

  always_ff @(posedge clk) begin
    sm <= sum_c;
  end

  // Normalize over the few positions the sum can lead at, then round.
  always_comb begin
    lz = 3'd7;
    for (int i = 7; i >= 0; i--) begin
      if (sm[56 - i]) begin
        lz = 3'(i);
      end
    end
    nrm  = sm << lz;
    mant = nrm[56:33];
    rb   = nrm[32];
    stc  = |nrm[31:0];
    mr   = {1'b0, mant} + 25'(rb & (stc | mant[0]));
    y_next.sgn = 1'b0;
    if (mr[24]) begin
      y_next.m = 24'h800000;
      y_next.e = 10'sd1 - $signed({7'b0, lz});
    end else begin
      y_next.m = mr[23:0];
      y_next.e = -$signed({7'b0, lz});
    end
  end

  always_ff @(posedge clk) begin
    y <= y_next;
  end

endmodule

// ===== hw/rtl/fp32_exp_polynomial_top.sv =====
// Single-precision exp(x) unit. One operand is taken in every clock cycle
// (busy always reads low) and its result appears with done at the end of
// the pipeline: seven stages for the range reduction, three for each of
// the four fused multiply-adds of the polynomial, and one for the final
// scaling. The receiver cannot stall the unit, so each result must be
// captured in the cycle that done is high.
// The operand x is reduced to r = x - k*ln2 with k the nearest integer to
// x*log2(e), the polynomial approximates exp(r), and the result is scaled by
// 2^k. NaN returns the quiet NaN of the input; a k above 127 (or +infinity)
// returns +infinity and a k below -126 (or -infinity) returns +0, both with
// range_flag set.
module fp32_exp_polynomial_top import fpexp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] x_bits,
  output logic        busy,
  output logic        done,
  output logic [31:0] exp_bits,
  output logic        range_flag
);

  // Valid bits travel one stage per cycle beside the data.
  logic [LATENCY:1] vld;

  // Stage 1: operand and the exact product with log2(e).
  logic [31:0] s1_x;
  logic [47:0] s1_prod;
  // Stage 2: v = x*log2(e) rounded to single precision.
  logic [31:0]       s2_x;
  logic [23:0]       s2_vm;
  logic signed [9:0] s2_ve;
  // Stage 3: k and the special-case decision.
  logic [31:0] s3_x;
  logic [9:0]  s3_kabs;
  // Stage 4: x and |k|*ln2 aligned on a grid of 2^-25.
  logic [31:0] s4_x;
  logic [32:0] s4_xal;
  logic [33:0] s4_kp;
  // Stage 5: raw r before normalization.
  logic [23:0]       s5_raw;
  logic signed [9:0] s5_eb;
  logic              s5_rs;
  // Stage 6: leading-zero count of r.
  logic [23:0]       s6_raw;
  logic signed [9:0] s6_eb;
  logic              s6_rs;
  logic [4:0]        s6_lz;

  // r is stage 7 and is delayed to meet each multiply-add in turn.
  ufp_t      r_st  [7:16];
  fpexp_sb_t sb_st [3:LATENCY-1];

  ufp_t p1;
  ufp_t p2;
  ufp_t p3;
  ufp_t p4;

  logic [7:0]        s1_ex;
  logic [23:0]       v_m;
  logic              v_rb;
  logic              v_st;
  logic signed [9:0] v_e;
  logic [24:0]       v_r;
  logic [23:0]       s2_vm_next;
  logic signed [9:0] s2_ve_next;

  logic signed [9:0] k_sh;
  logic [48:0]       k_ext;
  logic [23:0]       k_int;
  logic [24:0]       k_frac;
  logic [9:0]        k_rnd;
  logic [7:0]        s2_ex;
  logic              s2_sx;
  logic              s2_nan;
  logic              s2_inf;
  logic              s2_big;
  logic              s2_tiny;
  logic [9:0]        kabs_c;
  fpexp_sb_t         sb_c;

  logic [32:0] kp_c;

  logic [33:0]       xe;
  logic              ge;
  logic [33:0]       dmag;
  logic [7:0]        s4_ex;
  logic [23:0]       raw_c;
  logic signed [9:0] eb_c;
  logic              rs_c;

  logic [4:0] lz_c;

  logic signed [9:0] bsd;
  logic [23:0]       q_sub;
  logic [31:0]       exp_next;
  logic              flag_next;

  // No internal hazard: the pipeline accepts an operand in every cycle.
  assign busy = 1'b0;
  assign done = vld[LATENCY];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LATENCY-1:1], start & ~busy};
    end
  end

  // Stage 1.
  always_ff @(posedge clk) begin
    s1_x    <= x_bits;
    s1_prod <= {1'b1, x_bits[22:0]} * LOG2E_M;
  end

  // Round the product to 24 bits, nearest even.
  assign s1_ex = s1_x[30:23];

  always_comb begin
    if (s1_prod[47]) begin
      v_m  = s1_prod[47:24];
      v_rb = s1_prod[23];
      v_st = |s1_prod[22:0];
    end else begin
      v_m  = s1_prod[46:23];
      v_rb = s1_prod[22];
      v_st = |s1_prod[21:0];
    end
    v_e = $signed({2'b00, s1_ex}) - 10'sd127 + $signed({9'b0, s1_prod[47]});
    v_r = {1'b0, v_m} + 25'(v_rb & (v_st | v_m[0]));
    if (v_r[24]) begin
      s2_vm_next = 24'h800000;
      s2_ve_next = v_e + 10'sd1;
    end else begin
      s2_vm_next = v_r[23:0];
      s2_ve_next = v_e;
    end
  end

  always_ff @(posedge clk) begin
    s2_x  <= s1_x;
    s2_vm <= s2_vm_next;
    s2_ve <= s2_ve_next;
  end

  // Round v to the nearest integer, ties to even, and sort out the special
  // cases. Operands below 0.25 in magnitude always give k = 0, and operands
  // of 256 or more in magnitude always saturate.
  always_comb begin
    s2_ex   = s2_x[30:23];
    s2_sx   = s2_x[31];
    s2_nan  = (s2_ex == 8'hFF) && (s2_x[22:0] != 23'd0);
    s2_inf  = (s2_ex == 8'hFF) && (s2_x[22:0] == 23'd0);
    s2_big  = s2_ex >= 8'd135;
    s2_tiny = s2_ex < 8'd125;

    k_sh   = 10'sd23 - s2_ve;
    k_ext  = {s2_vm, 25'b0} >> k_sh[5:0];
    k_int  = k_ext[48:25];
    k_frac = k_ext[24:0];
    k_rnd  = k_int[9:0] + 10'(k_frac[24] & ((|k_frac[23:0]) | k_int[0]));
    kabs_c = s2_tiny ? 10'd0 : k_rnd;

    sb_c.k = s2_sx ? -$signed(kabs_c) : $signed(kabs_c);
    priority if (s2_nan) begin
      sb_c.ovr  = 1'b1;
      sb_c.bits = s2_x | QUIET_BIT;
      sb_c.flag = 1'b0;
    end else if (s2_inf || s2_big) begin
      sb_c.ovr  = 1'b1;
      sb_c.bits = s2_sx ? 32'd0 : POS_INF_BITS;
      sb_c.flag = 1'b1;
    end else if (!s2_sx && (kabs_c > 10'd127)) begin
      sb_c.ovr  = 1'b1;
      sb_c.bits = POS_INF_BITS;
      sb_c.flag = 1'b1;
    end else if (s2_sx && (kabs_c > 10'd126)) begin
      sb_c.ovr  = 1'b1;
      sb_c.bits = 32'd0;
      sb_c.flag = 1'b1;
    end else begin
      sb_c.ovr  = 1'b0;
      sb_c.bits = 32'd0;
      sb_c.flag = 1'b0;
    end
  end

  // Stage 3, and the delay line that carries the decision to the output.
  always_ff @(posedge clk) begin
    s3_x     <= s2_x;
    s3_kabs  <= kabs_c;
    sb_st[3] <= sb_c;
    for (int i = 4; i <= LATENCY - 1; i++) begin
      sb_st[i] <= sb_st[i-1];
    end
  end

  // Stage 4: exact |k|*ln2 and the aligned significand of x.
  assign kp_c = 33'(s3_kabs[8:0]) * 33'(LN2_M);

  always_ff @(posedge clk) begin
    s4_x   <= s3_x;
    s4_xal <= 33'({1'b1, s3_x[22:0]}) << 4'(s3_x[30:23] - 8'd125);
    s4_kp  <= {kp_c, 1'b0};
  end

  // Stage 5: the difference is exact and below 0.5, so it fits 24 bits.
  // Small operands bypass the reduction and give r = x directly.
  always_comb begin
    s4_ex = s4_x[30:23];
    xe    = {1'b0, s4_xal};
    ge    = xe >= s4_kp;
    dmag  = ge ? (xe - s4_kp) : (s4_kp - xe);
    if (s4_ex < 8'd125) begin
      raw_c = {s4_ex != 8'd0, s4_x[22:0]};
      eb_c  = (s4_ex == 8'd0) ? -10'sd126 : ($signed({2'b00, s4_ex}) - 10'sd127);
      rs_c  = s4_x[31];
    end else begin
      raw_c = dmag[23:0];
      eb_c  = -10'sd2;
      rs_c  = s4_x[31] ^ ~ge;
    end
  end

  always_ff @(posedge clk) begin
    s5_raw <= raw_c;
    s5_eb  <= eb_c;
    s5_rs  <= rs_c;
  end

  // Stage 6: leading-zero count; a zero r counts 24.
  always_comb begin
    lz_c = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (s5_raw[i]) begin
        lz_c = 5'(23 - i);
      end
    end
  end

  always_ff @(posedge clk) begin
    s6_raw <= s5_raw;
    s6_eb  <= s5_eb;
    s6_rs  <= s5_rs;
    s6_lz  <= lz_c;
  end

  // Stage 7: normalized r, then its delay line.
  always_ff @(posedge clk) begin
    r_st[7].sgn <= s6_rs;
    r_st[7].m   <= s6_raw << s6_lz;
    r_st[7].e   <= s6_eb - $signed({5'b0, s6_lz});
    for (int i = 8; i <= 16; i++) begin
      r_st[i] <= r_st[i-1];
    end
  end

  // Horner evaluation: p = 1 + r*(c1 + r*(c2 + r*(c3 + r*c4))).
  fpexp_fma u_fma1 (.clk(clk), .a(C4_F),     .b(r_st[7]),  .c(C3_F),  .y(p1));
  fpexp_fma u_fma2 (.clk(clk), .a(p1),       .b(r_st[10]), .c(C2_F),  .y(p2));
  fpexp_fma u_fma3 (.clk(clk), .a(p2),       .b(r_st[13]), .c(C1_F),  .y(p3));
  fpexp_fma u_fma4 (.clk(clk), .a(r_st[16]), .b(p3),       .c(ONE_F), .y(p4));

  // Final scaling by 2^k. With k in range and p below 2 the result never
  // overflows; only k = -126 with p below 1 lands in the subnormal range,
  // which costs one bit rounded to nearest even.
  always_comb begin
    bsd   = sb_st[LATENCY-1].k + p4.e + 10'sd127;
    q_sub = 24'(p4.m[23:1]) + 24'(p4.m[0] & p4.m[1]);
    if (sb_st[LATENCY-1].ovr) begin
      exp_next  = sb_st[LATENCY-1].bits;
      flag_next = sb_st[LATENCY-1].flag;
    end else if (bsd > 10'sd0) begin
      exp_next  = {1'b0, bsd[7:0], p4.m[22:0]};
      flag_next = 1'b0;
    end else begin
      exp_next  = {8'b0, q_sub};
      flag_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    exp_bits   <= exp_next;
    range_flag <= flag_next;
  end

endmodule

// ===== hw/rtl/fpexp_chk.sv =====
// Port-level checks for the exp unit.
module fpexp_chk import fpexp_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic [31:0] x_bits,
  input logic        busy,
  input logic        done,
  input logic [31:0] exp_bits,
  input logic        range_flag
);

  // Every transfer in produces a result a fixed number of cycles later.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LATENCY done)
    else $error("result missing after accepted operand");

  // No result without a transfer in.
  a_no_extra: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LATENCY))
    else $error("result without an accepted operand");

  // A saturated result is +infinity or +0.
  a_sat: assert property (@(posedge clk) disable iff (rst)
    (done && range_flag) |-> (exp_bits == POS_INF_BITS || exp_bits == 32'd0))
    else $error("range flag with unsaturated result");

  // NaN operands come back quieted, without the range flag.
  a_nan: assert property (@(posedge clk) disable iff (rst)
    (done && $past(x_bits[30:23], LATENCY) == 8'hFF
          && $past(x_bits[22:0], LATENCY) != 23'd0)
      |-> (exp_bits == ($past(x_bits, LATENCY) | QUIET_BIT) && !range_flag))
    else $error("NaN operand not propagated");

endmodule

bind fp32_exp_polynomial_top fpexp_chk u_fpexp_chk (.*);

// ===== sim/fp32_exp_polynomial_top_tb.sv =====
`timescale 1ns / 100ps

// Testbench for the single-precision exp(x) unit.
module fp32_exp_polynomial_top_tb;
  import fpexp_pkg::*;

  logic        clk;
  logic        rst;
  logic        start;
  logic [31:0] x_bits;
  logic        busy;
  logic        done;
  logic [31:0] exp_bits;
  logic        range_flag;

  // One expected result of the unit: the bit pattern and the saturation flag.
  typedef struct {
    logic [31:0] bits;
    logic        flag;
  } exp_result_t;

  exp_result_t expected_q[$];

  int unsigned mismatch_count = 0;
  int unsigned result_count   = 0;
  int unsigned xfer_count     = 0;
  int unsigned sat_count      = 0;
  int unsigned nan_count      = 0;
  bit          burst_mode     = 1'b0;

  fp32_exp_polynomial_top dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .x_bits     (x_bits),
    .busy       (busy),
    .done       (done),
    .exp_bits   (exp_bits),
    .range_flag (range_flag)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is done in double precision and rounded to
  // single precision exactly where the unit rounds.
  // ---------------------------------------------------------------------------

  // Round a double to single precision with ties to even, gradual underflow.
  function automatic logic [31:0] to_single(real d);
    logic [63:0] u;
    logic [63:0] m;
    logic [63:0] q;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] sg;
    int          e;
    int          fe;
    int          sh;
    u  = $realtobits(d);
    sg = {u[63], 31'b0};
    e  = int'(u[62:52]);
    m  = {12'b0, u[51:0]};
    if (e == 2047) begin
      return sg | POS_INF_BITS | ((m != 0) ? QUIET_BIT : 32'b0);
    end
    if (e == 0) begin
      return sg;
    end
    m  = m | (64'h1 << 52);
    fe = e - 1023 + 127;
    sh = 29;
    if (fe < 1) begin
      sh = 30 - fe;
    end
    if (sh > 60) begin
      return sg;
    end
    q    = m >> sh;
    rem  = m & ((64'h1 << sh) - 64'h1);
    half = 64'h1 << (sh - 1);
    if (rem > half || (rem == half && q[0])) begin
      q = q + 64'h1;
    end
    if (fe < 1) begin
      return sg | q[31:0];
    end
    if (q == (64'h1 << 24)) begin
      q  = q >> 1;
      fe = fe + 1;
    end
    if (fe >= 255) begin
      return sg | POS_INF_BITS;
    end
    return {sg[31], fe[7:0], q[22:0]};
  endfunction

  // Widen a finite single-precision pattern to a double.
  function automatic real from_single(logic [31:0] b);
    logic [10:0] de;
    real         v;
    if (b[30:23] == 8'd0) begin
      // Zero or subnormal: the significand times 2^-149 is exact.
      v = real'(b[22:0]) * (2.0 ** -149);
      return b[31] ? -v : v;
    end
    de = 11'(int'(b[30:23]) - 127 + 1023);
    return $bitstoreal({b[31], de, b[22:0], 29'b0});
  endfunction

  // a*b+c with a single rounding to single precision. The product of two
  // single values is exact in double; the sum is made sticky by nudging its
  // last bit when the double addition dropped something.
  function automatic real fused_madd(real a, real b, real c);
    real         p;
    real         s;
    real         bb;
    real         err;
    logic [63:0] u;
    p   = a * b;
    s   = p + c;
    bb  = s - p;
    err = (p - (s - bb)) + (c - bb);
    if (err != 0.0) begin
      u = $realtobits(s);
      if (!u[0]) begin
        if ((s > 0.0) == (err > 0.0)) begin
          u = u + 64'h1;
        end else begin
          u = u - 64'h1;
        end
        s = $bitstoreal(u);
      end
    end
    return from_single(to_single(s));
  endfunction

  // Expected exp(x) for one operand.
  function automatic exp_result_t predict_exp(logic [31:0] xb);
    exp_result_t res;
    real         log2e;
    real         ln2;
    real         c4;
    real         c3;
    real         c2;
    real         c1;
    real         x;
    real         v;
    real         frac;
    real         r;
    real         p;
    int          k;
    log2e = from_single(to_single(1.4426950408889634));
    ln2   = from_single(to_single(0.6931471805599453));
    c4    = from_single(to_single(0.042356002));
    c3    = from_single(to_single(0.166933063));
    c2    = from_single(to_single(0.499893348));
    c1    = from_single(to_single(1.000043123));
    res.flag = 1'b1;
    if (xb[30:23] == 8'hFF && xb[22:0] != 23'd0) begin
      // NaN comes back quieted with sign and payload kept.
      res.bits = xb | QUIET_BIT;
      res.flag = 1'b0;
      return res;
    end
    if (xb[30:23] == 8'hFF) begin
      res.bits = xb[31] ? 32'd0 : POS_INF_BITS;
      return res;
    end
    x = from_single(xb);
    v = from_single(to_single(x * log2e));
    if (v > 256.0) begin
      res.bits = POS_INF_BITS;
      return res;
    end
    if (v < -256.0) begin
      res.bits = 32'd0;
      return res;
    end
    // Truncate, then round to nearest with ties to even.
    k    = $rtoi(v);
    frac = v - real'(k);
    if (frac > 0.5 || (frac == 0.5 && k[0])) begin
      k = k + 1;
    end else if (frac < -0.5 || (frac == -0.5 && k[0])) begin
      k = k - 1;
    end
    if (k > 127) begin
      res.bits = POS_INF_BITS;
      return res;
    end
    if (k < -126) begin
      res.bits = 32'd0;
      return res;
    end
    r = fused_madd(-real'(k), ln2, x);
    p = fused_madd(c4, r, c3);
    p = fused_madd(p, r, c2);
    p = fused_madd(p, r, c1);
    p = fused_madd(r, p, 1.0);
    res.bits = to_single(from_single(32'(k + 127) << 23) * p);
    res.flag = 1'b0;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitors. Both run on the rising edge and see the values from before it,
  // so the unit's own updates at that edge cannot race them.
  // ---------------------------------------------------------------------------

  // Every operand transfer queues its prediction.
  always @(posedge clk) begin
    if (!rst && start && !busy) begin
      expected_q.push_back(predict_exp(x_bits));
      xfer_count++;
    end
  end

  // Every done strobe is one result; it is matched against the oldest
  // prediction. The receiver cannot hold results, so nothing stalls here.
  always @(posedge clk) begin
    exp_result_t want;
    if (!rst && done) begin
      result_count++;
      if (expected_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("ERROR: unexpected result exp_bits=%h range_flag=%b",
                   exp_bits, range_flag);
        end
      end else begin
        want = expected_q.pop_front();
        if (want.flag) begin
          sat_count++;
        end
        if (want.bits[30:23] == 8'hFF && want.bits[22:0] != 23'd0) begin
          nan_count++;
        end
        if (exp_bits !== want.bits || range_flag !== want.flag) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("ERROR: exp_bits exp %h got %h, range_flag exp %b got %b",
                     want.bits, exp_bits, want.flag, range_flag);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side.
  // ---------------------------------------------------------------------------

  // Send one operand. start stays high after the transfer, so a following
  // call with no gap keeps the stream going without a bubble; a gap lowers it
  // first.
  task automatic send_x(logic [31:0] xb);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    x_bits <= xb;
    do begin
      @(posedge clk);
    end while (busy);
  endtask

  // Stop sending and wait until every queued result has come back, then
  // let the pipeline run empty.
  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // A finite value of moderate size: exponents chosen so that k runs past
  // both saturation limits but most values stay in the useful range.
  function automatic logic [31:0] rand_moderate();
    logic [7:0] ex;
    ex = 8'($urandom_range(100, 133));
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Field extremes and every special case, back to back.
  task automatic test_directed;
    burst_mode = 1'b1;
    send_x(32'h0000_0000);  // +0 gives exactly one
    send_x(32'h8000_0000);  // -0
    send_x(32'h0000_0001);  // smallest subnormal
    send_x(32'h807F_FFFF);  // largest negative subnormal
    send_x(32'h7F7F_FFFF);  // largest finite: product overflows to infinity
    send_x(32'hFF7F_FFFF);  // most negative finite
    send_x(32'h7F80_0000);  // +infinity
    send_x(32'hFF80_0000);  // -infinity
    send_x(32'h7FC0_0000);  // quiet NaN
    send_x(32'h7F80_0001);  // signaling NaN gets its quiet bit set
    send_x(32'hFFBF_FFFF);  // negative signaling NaN, full payload
    send_x(32'hFFFF_FFFF);  // all ones
    send_x(32'h3F80_0000);  // 1.0
    send_x(32'hBF80_0000);  // -1.0
    send_x(32'h3EB1_7218);  // ln2/2: a tie for the rounding of k
    send_x(32'h3F85_1592);  // 1.5*ln2
    send_x(32'h42B1_7218);  // 128*ln2: just past the top of k
    send_x(32'h42B0_0000);  // 88.0: k = 127, the top of the range for k
    send_x(32'h42B1_0000);  // 88.5
    send_x(32'hC2AE_0000);  // -87.0: k = -126 with a normal result
    send_x(32'hC2AF_0000);  // -87.5: k = -126 with a subnormal result
    send_x(32'hC2B0_0000);  // -88.0: k below -126
    send_x(32'h4B80_0000);  // 2^24: v far above 256
    send_x(32'hCB80_0000);  // -2^24: v far below -256
    drain();
  endtask

  // Operands in and around the useful range with random idle gaps, and
  // stretches of back-to-back transfers.
  task automatic test_random_moderate(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 100 == 0) begin
        burst_mode = $urandom_range(0, 2) == 0;
      end
      send_x(rand_moderate());
    end
    drain();
  endtask

  // Any 32-bit pattern: covers every bit of the operand both ways, NaN
  // payloads and the extreme exponents.
  task automatic test_random_bits(int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if (i % 80 == 0) begin
        burst_mode = $urandom_range(0, 2) == 0;
      end
      send_x($urandom());
    end
    drain();
  endtask

  // Tiny operands, where the result stays close to one and r carries most
  // of the precision.
  task automatic test_random_tiny(int unsigned n);
    burst_mode = 1'b0;
    for (int unsigned i = 0; i < n; i++) begin
      send_x({1'($urandom), 8'($urandom_range(0, 110)), 23'($urandom)});
    end
    drain();
  endtask

  initial begin
    rst    = 1'b1;
    start  = 1'b0;
    x_bits = 32'd0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_moderate(900);
    test_random_bits(350);
    test_random_tiny(150);

    $display("Checked %0d transfers and %0d results, %0d saturated and %0d NaN.",
             xfer_count, result_count, sat_count, nan_count);
    $display("Operands covered zeros, subnormals, infinities, NaNs and both range limits.");
    if (mismatch_count == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("Mismatches: %0d, results still missing: %0d",
               mismatch_count, expected_q.size());
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Timeout with %0d results outstanding", expected_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
